// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion helpers, clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bsc_pkg.sv -----
package bsc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int FRAC_BITS  = 4;

    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CNT_W      = 23;
    localparam int SUM_W      = 33;
    localparam int OUT_W      = 15;
    localparam int DVD_W      = SUM_W + FRAC_BITS;
    localparam int REM_W      = CNT_W + 1;
    localparam int STEP_W     = $clog2(OUT_W);

    localparam int COEF_W     = 14;
    localparam int ACC_W      = 22;
    localparam int GRAY_SHIFT = 14;

    localparam logic [COEF_W-1:0] COEF_B     = COEF_W'(1868);
    localparam logic [COEF_W-1:0] COEF_G     = COEF_W'(9617);
    localparam logic [COEF_W-1:0] COEF_R     = COEF_W'(4899);
    localparam logic [ACC_W-1:0]  GRAY_ROUND = ACC_W'(8192);

    localparam logic [PIX_W-1:0]  THR_RESET  = PIX_W'(250);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(MAX_HEIGHT - 1);
    localparam logic [OUT_W-1:0]  OUT_MAX    = '1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_pixel;

endpackage

// ----- hw/rtl/bsc_gray.sv -----
module bsc_gray (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bsc_pkg::t_pixel     i_pixel,
    output logic                o_done,
    output bsc_pkg::t_pix       o_gray
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {
        MAC_B,
        MAC_G,
        MAC_R
    } t_mac_step;

    t_mac_step          r_step;
    logic               r_busy;
    logic               r_done;
    t_pixel             r_pixel;
    logic [ACC_W-1:0]   r_acc;

    logic [COEF_W-1:0]  coef;
    t_pix               opnd;
    logic [ACC_W-1:0]   base;
    logic [ACC_W-1:0]   n_acc;

    always_comb begin
        case (r_step)
            MAC_B: begin
                coef = COEF_B;
                opnd = r_pixel.blue;
            end
            MAC_G: begin
                coef = COEF_G;
                opnd = r_pixel.green;
            end
            MAC_R: begin
                coef = COEF_R;
                opnd = r_pixel.red;
            end
            default: begin
                coef = '0;
                opnd = '0;
            end
        endcase
        base  = (r_step == MAC_B) ? GRAY_ROUND : r_acc;
        n_acc = base + ACC_W'(ACC_W'(coef) * ACC_W'(opnd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= MAC_B;
        end else begin
            r_done <= r_busy && (r_step == MAC_R);
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_step  <= MAC_B;
                r_pixel <= i_pixel;
            end else if (r_busy) begin
                r_acc <= n_acc;
                case (r_step)
                    MAC_B:   r_step <= MAC_G;
                    MAC_G:   r_step <= MAC_R;
                    MAC_R: begin
                        r_busy <= 1'b0;
                        r_step <= MAC_B;
                    end
                    default: r_step <= MAC_B;
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_gray = r_acc[GRAY_SHIFT +: PIX_W];

`include "assert_macros.svh"

    `ASSERT_CLK(a_gray_done_idle, r_done |-> !r_busy, "gray done while still accumulating")

endmodule

// ----- hw/rtl/bsc_div.sv -----
module bsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bsc_pkg::DVD_W-1:0]   i_dividend,
    input  logic [bsc_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [bsc_pkg::OUT_W-1:0]   o_quotient
);
    import bsc_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [STEP_W-1:0]  r_step;
    logic [REM_W-1:0]   r_rem;
    logic [OUT_W-1:0]   r_low;
    logic [OUT_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_div;

    logic [REM_W-1:0]   start_rem;
    logic [REM_W-1:0]   trial;
    logic               fits;

    always_comb begin
        start_rem = REM_W'(i_dividend[DVD_W-1:OUT_W]);
        trial     = {r_rem[REM_W-2:0], r_low[OUT_W-1]};
        fits      = trial >= REM_W'(r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == STEP_W'(OUT_W - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_div  <= i_divisor;
                r_rem  <= start_rem;
                r_low  <= i_dividend[OUT_W-1:0];
                r_sat  <= start_rem >= REM_W'(i_divisor);
                r_quo  <= '0;
            end else if (r_busy) begin
                if (!r_sat) begin
                    r_rem <= fits ? trial - REM_W'(r_div) : trial;
                end
                r_quo <= {r_quo[OUT_W-2:0], fits};
                r_low <= {r_low[OUT_W-2:0], 1'b0};
                if (r_step == STEP_W'(OUT_W - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sat ? OUT_MAX : r_quo;

`include "assert_macros.svh"

    `ASSERT_CLK(a_rem_below_div, r_busy && !r_sat |-> r_rem < REM_W'(r_div), "remainder too large")
    `ASSERT_CLK(a_done_after_busy, r_done |-> $past(r_busy), "divider done without a run")

endmodule

// ----- hw/rtl/bright_spot_centroid.sv -----
// Bright-spot centroid over a raster frame. Input stalls while each pixel is in work: one
// shared 14x8 multiply-accumulate unit forms the gray value in three passes, then the bright
// test and the position sums update. A frame-end pixel with bright pixels then passes through a
// shared restoring divider that produces 15 quotient bits one per cycle, first for x, then for
// y; a frame-end pixel without bright pixels skips the divider. The result sits in an output
// register; the next frame runs while it waits, and a second frame end stalls only if
// the first result is still not taken. Centroids are unsigned with 4 fraction bits, truncated;
// tuser of the result is 0 and both coordinates are 0 for a frame without bright pixels. The
// threshold register resets to 250 and should be written while idle.
module bright_spot_centroid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // threshold write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic        s_axis_tlast,   // line_end
    input  logic        s_axis_tuser,   // frame_end
    // centroid stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // centroid_x[14:0], centroid_y[29:15], zero[31:30]
    output logic        m_axis_tuser    // found
);
    import bsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAY,
        ST_DIVX,
        ST_DIVY,
        ST_DONE
    } t_state;

    t_state             r_state;
    t_pix               r_thr;
    logic               r_line_end;
    logic               r_frame_end;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_sx;
    logic [SUM_W-1:0]   r_sy;
    logic [CNT_W-1:0]   r_fcnt;
    logic [SUM_W-1:0]   r_fsx;
    logic [SUM_W-1:0]   r_fsy;
    logic               r_div_start;
    logic [OUT_W-1:0]   r_qx;
    logic [OUT_W-1:0]   r_qy;
    logic               r_found;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_x;
    logic [OUT_W-1:0]   r_out_y;
    logic               r_out_found;

    logic [CNT_W-1:0]   n_cnt;
    logic [SUM_W-1:0]   n_sx;
    logic [SUM_W-1:0]   n_sy;

    t_pixel             pixel;
    logic               in_xfer;
    logic               out_xfer;
    logic               gray_done;
    t_pix               gray;
    logic               bright;
    logic               div_done;
    logic               div_launch;
    logic [OUT_W-1:0]   quotient;
    logic [DVD_W-1:0]   dividend;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign pixel         = t_pixel'(s_axis_tdata);
    assign dividend      = DVD_W'(r_state == ST_DIVY ? r_fsy : r_fsx) << FRAC_BITS;
    assign div_launch    = (r_state == ST_GRAY && gray_done && r_frame_end && n_cnt != '0)
                        || (r_state == ST_DIVX && div_done);

    bsc_gray u_gray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_pixel (pixel),
        .o_done  (gray_done),
        .o_gray  (gray)
    );

    bsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (dividend),
        .i_divisor  (r_fcnt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        bright = gray > r_thr;
        n_cnt  = r_cnt;
        n_sx   = r_sx;
        n_sy   = r_sy;
        if (bright) begin
            n_cnt = r_cnt + 1'b1;
            n_sx  = r_sx + SUM_W'(r_col);
            n_sy  = r_sy + SUM_W'(r_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= THR_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= div_launch;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (out_xfer && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_line_end  <= s_axis_tlast;
                        r_frame_end <= s_axis_tuser;
                        r_state     <= ST_GRAY;
                    end
                end
                ST_GRAY: begin
                    if (gray_done) begin
                        if (r_frame_end) begin
                            r_fcnt  <= n_cnt;
                            r_fsx   <= n_sx;
                            r_fsy   <= n_sy;
                            r_found <= (n_cnt != '0);
                            r_col   <= '0;
                            r_row   <= '0;
                            r_cnt   <= '0;
                            r_sx    <= '0;
                            r_sy    <= '0;
                            if (n_cnt != '0) begin
                                r_state <= ST_DIVX;
                            end else begin
                                r_qx    <= '0;
                                r_qy    <= '0;
                                r_state <= ST_DONE;
                            end
                        end else begin
                            r_cnt   <= n_cnt;
                            r_sx    <= n_sx;
                            r_sy    <= n_sy;
                            r_state <= ST_IDLE;
                            if (r_line_end) begin
                                r_col <= '0;
                                if (r_row != ROW_LAST) begin
                                    r_row <= r_row + 1'b1;
                                end
                            end else if (r_col != COL_LAST) begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                ST_DIVX: begin
                    if (div_done) begin
                        r_qx    <= quotient;
                        r_state <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    if (div_done) begin
                        r_qy    <= quotient;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_qx;
                        r_out_y     <= r_qy;
                        r_out_found <= r_found;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 32'({r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_found;

`include "assert_macros.svh"

    `ASSERT_CLK(a_gray_in_gray, gray_done |-> r_state == ST_GRAY, "gray done out of step")
    `ASSERT_CLK(a_div_in_div, div_done |-> r_state == ST_DIVX || r_state == ST_DIVY, "div misstep")
    `ASSERT_CLK(a_empty_zero, r_out_valid && !r_out_found |-> {r_out_x, r_out_y} == '0, "bad empty")

endmodule
